// ----- design/chmp_pkg.sv -----
// ----------------------------------------------------------------------------
// chmp_pkg: shared types and constants of the cache hit/miss predictor
// Holds parameter defaults, register indexes, item mode codes, the controller
// state type and the configuration bundle passed to the index hash.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package chmp_pkg;

  // Parameter defaults
  localparam int unsigned DEF_INDEX_BITS   = 10;
  localparam int unsigned DEF_COUNTER_BITS = 2;

  // Configuration port geometry
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WORD_SHIFT = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FOLD_INDEX = 4'd1;

  // Register reset values
  localparam logic [1:0] WORD_SHIFT_RST = 2'd2;
  localparam logic       FOLD_INDEX_RST = 1'b0;

  // Item mode codes
  localparam logic MODE_PREDICT = 1'b0;
  localparam logic MODE_COMMIT  = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } chmp_state_t;

  // Configuration bundle
  typedef struct packed {
    logic [1:0] word_shift;
    logic       fold_index;
  } chmp_cfg_t;

endpackage

`default_nettype wire

// ----- design/chmp_index.sv -----
// ----------------------------------------------------------------------------
// chmp_index: table index hash
// Shifts the instruction address, XORs in the thread id and either keeps the
// low index bits or XOR-folds the whole 64-bit word into index-wide chunks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chmp_index
  import chmp_pkg::*;
#(
  parameter int unsigned INDEX_BITS = DEF_INDEX_BITS
) (
  input  chmp_cfg_t               cfg,
  input  logic [63:0]             pc_address,
  input  logic [7:0]              thread_id,
  output logic [INDEX_BITS-1:0]   index
);

  localparam int unsigned NumChunks = (64 + INDEX_BITS - 1) / INDEX_BITS;
  localparam int unsigned PadW      = NumChunks * INDEX_BITS;

  logic [63:0]           word;
  logic [PadW-1:0]       padded;
  logic [INDEX_BITS-1:0] folded;

  // Hash address and thread, then fold or mask
  always_comb begin
    word   = (pc_address >> cfg.word_shift) ^ {56'd0, thread_id};
    padded = PadW'(word);
    folded = '0;
    for (int c = 0; c < NumChunks; c++) begin
      folded = folded ^ padded[c*INDEX_BITS +: INDEX_BITS];
    end
    index = cfg.fold_index ? folded : word[INDEX_BITS-1:0];
  end

endmodule

`default_nettype wire

// ----- design/counter_hit_miss_predictor.sv -----
// ----------------------------------------------------------------------------
// counter_hit_miss_predictor: saturating-counter cache hit/miss predictor
// Table of 2^INDEX_BITS counters in one synchronous memory, indexed by a
// hash of instruction address and thread id.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one item: a predict lookup
//   (in_mode = 0) or a commit update (in_mode = 1) with its outcome in
//   in_was_hit. A predict item gives one result on the output channel
//   (out_valid/out_ready, out_predict_hit); a commit item gives none.
//   Items are handled one at a time: the accept cycle issues the memory read,
//   then the registered counter is used to answer or to write the updated
//   counter back. in_ready stays low until that read-modify-write is done, so
//   a new item is not taken while one is in execution; a predict result is
//   formed from the counter in rd_data_r and then held in the output register.
//   Reset: rst_n is synchronous, active low. After reset the block runs a
//   clearing pass that writes the midpoint into all 2^INDEX_BITS counters;
//   in_ready stays low meanwhile.
//   Configuration writes (cfg_wr_en) are taken in any cycle.
//   Stall: a result waits in the output register until out_ready; a predict
//   item that finds it still occupied holds the block until it drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module counter_hit_miss_predictor
  import chmp_pkg::*;
#(
  parameter int unsigned INDEX_BITS   = DEF_INDEX_BITS,
  parameter int unsigned COUNTER_BITS = DEF_COUNTER_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration port
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_mode,
  input  logic [63:0]            in_pc_address,
  input  logic [7:0]             in_thread_id,
  input  logic                   in_was_hit,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_predict_hit
);

  localparam int unsigned Depth = 1 << INDEX_BITS;
  localparam logic [COUNTER_BITS-1:0] CtrMax = '1;
  localparam logic [COUNTER_BITS-1:0] CtrMid = COUNTER_BITS'(1 << (COUNTER_BITS - 1));
  localparam logic [COUNTER_BITS:0]   MissStep = (COUNTER_BITS + 1)'(2);

  chmp_state_t             state_r, state_nxt;
  chmp_cfg_t               cfg_r, cfg_nxt;
  logic [INDEX_BITS-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [INDEX_BITS-1:0]   in_idx;
  logic [INDEX_BITS-1:0]   idx_r;
  logic                    mode_r;
  logic                    was_hit_r;
  logic [COUNTER_BITS-1:0] rd_data_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_hit_r;

  logic                    accept;
  logic                    out_free;
  logic                    rd_en;
  logic                    mem_we;
  logic [INDEX_BITS-1:0]   mem_wa;
  logic [COUNTER_BITS-1:0] mem_wd;
  logic [COUNTER_BITS-1:0] ctr_upd;
  logic                    load_out;

  logic [COUNTER_BITS-1:0] mem [Depth];

  // Index hash
  chmp_index #(
    .INDEX_BITS (INDEX_BITS)
  ) u_index (
    .cfg        (cfg_r),
    .pc_address (in_pc_address),
    .thread_id  (in_thread_id),
    .index      (in_idx)
  );

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Decode configuration writes; drop unknown indexes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WORD_SHIFT: cfg_nxt.word_shift = cfg_wdata[1:0];
        REG_FOLD_INDEX: cfg_nxt.fold_index = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_cnt_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (mode_r == MODE_COMMIT || out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Saturating counter update
  always_comb begin
    if (was_hit_r) begin
      ctr_upd = (rd_data_r != CtrMax) ? rd_data_r + COUNTER_BITS'(1) : rd_data_r;
    end else begin
      ctr_upd = ({1'b0, rd_data_r} >= MissStep) ?
                rd_data_r - MissStep[COUNTER_BITS-1:0] : '0;
    end
  end

  // Controller outputs
  always_comb begin
    in_ready    = 1'b0;
    rd_en       = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = idx_r;
    mem_wd      = ctr_upd;
    load_out    = 1'b0;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_cnt_r;
        mem_wd      = CtrMid;
        clr_cnt_nxt = clr_cnt_r + INDEX_BITS'(1);
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_valid;
      end
      ST_EXEC: begin
        mem_we   = (mode_r == MODE_COMMIT);
        load_out = (mode_r == MODE_PREDICT) && out_free;
      end
      default: ;
    endcase
  end

  // Output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (load_out) out_valid_nxt = 1'b1;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      cfg_r       <= '{word_shift: WORD_SHIFT_RST, fold_index: FOLD_INDEX_RST};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold item payload and result
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r     <= in_idx;
      mode_r    <= in_mode;
      was_hit_r <= in_was_hit;
    end
    if (load_out) begin
      out_hit_r <= (rd_data_r >= CtrMid);
    end
  end

  // Counter memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[in_idx];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_predict_hit = out_hit_r;

  // Clearing pass keeps the input closed
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("item accepted during clearing pass");

  // Clearing pass does not end early
  a_clear_runs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && clr_cnt_r != '1) |=> (state_r == ST_CLEAR))
    else $error("clearing pass ended before the last entry");

  // Accepted item goes to execution next cycle
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted item did not enter execution");

  // Only a predict item raises a result
  a_result_from_predict: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC && mode_r == MODE_PREDICT))
    else $error("result raised without a predict item");

endmodule

`default_nettype wire

// ----- tb/sv/counter_hit_miss_predictor_test.sv -----
// ----------------------------------------------------------------------------
// counter_hit_miss_predictor_test: self-checking bench for the hit/miss predictor
// Drives predict and commit items through the valid/ready input channel and
// keeps a shadow counter array and register copy to forecast each predict
// answer. Covers counter saturation at both ends, index aliasing, every
// register setting extreme, ignored register writes, random sender bursts,
// receiver stalls and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module counter_hit_miss_predictor_test;
  import chmp_pkg::*;

  localparam int IDX_W        = DEF_INDEX_BITS;
  localparam int CTR_W        = DEF_COUNTER_BITS;
  localparam int SLOTS        = 1 << IDX_W;
  localparam int CTR_MAX      = (1 << CTR_W) - 1;
  localparam int CTR_MID      = 1 << (CTR_W - 1);
  localparam int HIT_STEP     = 1;
  localparam int MISS_PENALTY = 2;
  localparam int POOL_SIZE    = 12;
  localparam int PHASE_ITEMS  = 206;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 120;

  // Register indexes that map to nothing
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 4'hF;

  typedef struct {
    logic        mode;
    logic [63:0] pc;
    logic [7:0]  tid;
    logic        was_hit;
  } lookup_item_t;

  typedef enum logic [1:0] {
    RDY_FULL,
    RDY_HALF,
    RDY_MOSTLY,
    RDY_SPARSE
  } ready_pattern_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_mode = MODE_PREDICT;
  logic [63:0]            in_pc_address = '0;
  logic [7:0]             in_thread_id = '0;
  logic                   in_was_hit = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_predict_hit;

  // Shadow state of the predictor
  logic [CTR_W-1:0] hit_counters [SLOTS];
  logic [1:0]       cur_word_shift = WORD_SHIFT_RST;
  logic             cur_fold = FOLD_INDEX_RST;

  lookup_item_t pending_items [$];
  logic         predicted_hits [$];
  lookup_item_t cur_item;

  int items_accepted  = 0;
  int predicts_seen   = 0;
  int commits_seen    = 0;
  int results_checked = 0;
  int settings_used   = 1;
  int fail_count      = 0;

  counter_hit_miss_predictor dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_pc_address   (in_pc_address),
    .in_thread_id    (in_thread_id),
    .in_was_hit      (in_was_hit),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_predict_hit (out_predict_hit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Map address and thread to a counter slot under the current settings
  function automatic int unsigned hash_slot(logic [63:0] pc, logic [7:0] tid);
    logic [63:0]      v;
    logic [63:0]      chunk;
    logic [IDX_W-1:0] acc;
    v = (pc >> cur_word_shift) ^ {56'd0, tid};
    if (!cur_fold) return 32'(v[IDX_W-1:0]);
    acc = '0;
    for (int pos = 0; pos < 64; pos += IDX_W) begin
      chunk = v >> pos;
      acc = acc ^ chunk[IDX_W-1:0];
    end
    return 32'(acc);
  endfunction

  // Advance the shadow counters by one accepted item
  function automatic void step_predictor(lookup_item_t it);
    int unsigned slot;
    int          cnt;
    slot = hash_slot(it.pc, it.tid);
    cnt  = int'(hit_counters[slot]);
    if (it.mode == MODE_PREDICT) begin
      predicted_hits.push_back(cnt >= CTR_MID);
    end else begin
      if (it.was_hit) cnt = (cnt + HIT_STEP > CTR_MAX) ? CTR_MAX : cnt + HIT_STEP;
      else cnt = (cnt >= MISS_PENALTY) ? cnt - MISS_PENALTY : 0;
      hit_counters[slot] = cnt[CTR_W-1:0];
    end
  endfunction

  task automatic add_item(logic mode, logic [63:0] pc, logic [7:0] tid, logic was_hit);
    lookup_item_t it;
    it.mode    = mode;
    it.pc      = pc;
    it.tid     = tid;
    it.was_hit = was_hit;
    pending_items.push_back(it);
  endtask

  // Random items: mostly a small pool of hot addresses, each with its own
  // hit bias so counters saturate both ways, the rest fully random
  task automatic fill_random(int n);
    logic [63:0] pool_pc [POOL_SIZE];
    logic [7:0]  pool_tid [POOL_SIZE];
    int          pool_bias [POOL_SIZE];
    int          k;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_pc[i]   = {$urandom, $urandom};
      pool_tid[i]  = 8'($urandom_range(0, 255));
      pool_bias[i] = ($urandom_range(0, 2) == 0) ? 10 : ($urandom_range(0, 1) ? 50 : 90);
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, POOL_SIZE - 1);
        add_item($urandom_range(0, 1) ? MODE_COMMIT : MODE_PREDICT, pool_pc[k], pool_tid[k],
                 $urandom_range(0, 99) < pool_bias[k]);
      end else begin
        add_item($urandom_range(0, 1) ? MODE_COMMIT : MODE_PREDICT, {$urandom, $urandom},
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Wait until every item is taken and every answer back, then let the
  // last commit write-back settle
  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || predicted_hits.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_WORD_SHIFT: cur_word_shift = data[1:0];
      REG_FOLD_INDEX: cur_fold = data[0];
      default: ;
    endcase
  endtask

  // Driver: offer items in bursts, update the shadow state on accept
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    logic next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        step_predictor(cur_item);
        items_accepted++;
        if (cur_item.mode == MODE_PREDICT) predicts_seen++;
        else commits_seen++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() != 0) begin
          cur_item = pending_items.pop_front();
          in_mode       <= cur_item.mode;
          in_pc_address <= cur_item.pc;
          in_thread_id  <= cur_item.tid;
          in_was_hit    <= cur_item.was_hit;
          next_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = $urandom_range(0, 8);
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // Receiver: segments of differing ready density, plus one long hold-off
  ready_pattern_t ready_kind = RDY_FULL;
  int             seg_left   = 0;
  int             hold_left  = 0;
  logic           hold_done  = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && items_accepted >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        ready_kind <= ready_pattern_t'($urandom_range(0, 3));
        seg_left   <= $urandom_range(8, 40);
      end else begin
        seg_left <= seg_left - 1;
      end
      case (ready_kind)
        RDY_FULL:   out_ready <= 1'b1;
        RDY_HALF:   out_ready <= 1'($urandom_range(0, 1));
        RDY_MOSTLY: out_ready <= ($urandom_range(0, 9) != 0);
        default:    out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Monitor: compare each result with the oldest forecast
  always @(posedge clk) begin
    logic want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_hits.size() == 0) begin
        $error("predict_hit: expected no result, got %0b", out_predict_hit);
        fail_count++;
      end else begin
        want = predicted_hits.pop_front();
        results_checked++;
        if (out_predict_hit !== want) begin
          $error("predict_hit: expected %0b, got %0b", want, out_predict_hit);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [1:0] shift_plan [5];
    logic       fold_plan [5];
    shift_plan = '{2'd0, 2'd3, 2'd1, 2'd3, 2'd2};
    fold_plan  = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    for (int i = 0; i < SLOTS; i++) hit_counters[i] = CTR_MID[CTR_W-1:0];

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: walk one counter from midpoint to both ends
    add_item(MODE_PREDICT, 64'd0, 8'd0, 1'b1);
    add_item(MODE_COMMIT,  64'd0, 8'd0, 1'b0);
    add_item(MODE_PREDICT, 64'd0, 8'd0, 1'b0);
    add_item(MODE_COMMIT,  64'd0, 8'd0, 1'b1);
    add_item(MODE_COMMIT,  64'd0, 8'd0, 1'b1);
    add_item(MODE_PREDICT, 64'd0, 8'd0, 1'b0);
    add_item(MODE_COMMIT,  64'd0, 8'd0, 1'b1);
    add_item(MODE_COMMIT,  64'd0, 8'd0, 1'b1);
    add_item(MODE_PREDICT, 64'd0, 8'd0, 1'b1);
    add_item(MODE_COMMIT,  64'd0, 8'd0, 1'b0);
    add_item(MODE_PREDICT, 64'd0, 8'd0, 1'b0);
    add_item(MODE_COMMIT,  64'd0, 8'd0, 1'b0);
    add_item(MODE_PREDICT, 64'd0, 8'd0, 1'b0);
    // Address and thread aliasing onto the same slot
    add_item(MODE_COMMIT,  64'd4, 8'd0, 1'b0);
    add_item(MODE_PREDICT, 64'd0, 8'd1, 1'b0);
    // All-ones extremes
    add_item(MODE_PREDICT, {64{1'b1}}, 8'hFF, 1'b1);
    add_item(MODE_COMMIT,  {64{1'b1}}, 8'hFF, 1'b1);
    wait_idle();

    // Writes to unmapped indexes must leave settings alone
    write_reg(REG_UNUSED_LO, 2'd3);
    write_reg(REG_UNUSED_HI, 2'd1);
    write_reg(REG_FOLD_INDEX, 2'd1);
    write_reg(REG_WORD_SHIFT, 2'd0);
    settings_used++;
    add_item(MODE_COMMIT,  {64{1'b1}}, 8'h00, 1'b0);
    add_item(MODE_PREDICT, {64{1'b1}}, 8'h00, 1'b0);
    add_item(MODE_PREDICT, {64{1'b1}}, 8'hFF, 1'b0);
    wait_idle();

    // Upper data bit of the fold register is dropped
    write_reg(REG_FOLD_INDEX, 2'd2);
    write_reg(REG_WORD_SHIFT, 2'd3);
    settings_used++;
    add_item(MODE_COMMIT,  64'd8, 8'd1, 1'b1);
    add_item(MODE_PREDICT, 64'd0, 8'd0, 1'b1);
    add_item(MODE_PREDICT, {$urandom, $urandom}, 8'($urandom_range(0, 255)), 1'b0);

    // Random phases, one register setting each
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      if ($urandom_range(0, 1))
        write_reg(CFG_INDEX_W'(REG_UNUSED_LO + $urandom_range(0, 13)), CFG_DATA_W'($urandom));
      write_reg(REG_WORD_SHIFT, shift_plan[p]);
      write_reg(REG_FOLD_INDEX, {1'($urandom_range(0, 1)), fold_plan[p]});
      settings_used++;
      fill_random(PHASE_ITEMS);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (predicted_hits.size() != 0) begin
      $error("predict_hit: %0d results never arrived", predicted_hits.size());
      fail_count++;
    end

    $display("Ran %0d items (%0d predicts, %0d commits) under %0d register settings,",
             items_accepted, predicts_seen, commits_seen, settings_used);
    $display("checked %0d predictions, %0d failures.", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("counter_hit_miss_predictor_test OK");
    end else begin
      $display("counter_hit_miss_predictor_test NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("counter_hit_miss_predictor_test NOT OK");
    $finish;
  end

endmodule
